>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define NRC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("nrc assertion failed");
// expr must never be true outside reset
`define NRC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("nrc forbidden condition seen");
`else
`define NRC_ASSERT(lbl, clk, rst_n, prop)
`define NRC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> design/nrc_pkg.sv
// ----------------------------------------------------------------------------
// nrc_pkg
// Shared types and constants of the nested rectangle chain block.
// ----------------------------------------------------------------------------
package nrc_pkg;

	localparam int SIDE_W   = 16;
	localparam int LEN_W    = 8;
	localparam int SUM_W    = 39;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_GROW_MODE       = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PREFER_MAX_AREA = 1'b1;

	typedef struct packed {
		logic [SIDE_W-1:0] side_a;
		logic [SIDE_W-1:0] side_b;
		logic              last_item;
	} item_t;

	typedef struct packed {
		logic [LEN_W-1:0] chain_length;
		logic [SUM_W-1:0] chain_area;
	} result_t;

	typedef struct packed {
		logic grow_mode;
		logic prefer_max_area;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic scan;
		logic write;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic scan_last;
		logic last_item;
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_FINISH
	} state_t;

endpackage

>>> design/nrc_ctrl.sv
// ----------------------------------------------------------------------------
// nrc_ctrl
// Sequencer: load, area multiply, scan of stored entries, drain, store, result.
// ----------------------------------------------------------------------------
module nrc_ctrl import nrc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output logic    busy,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (status.full)       state_d = ST_FINISH;
				else if (status.empty) state_d = ST_WRITE;
				else                   state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN:  state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_MUL:    cmd.mul   = 1'b1;
			ST_SCAN:   cmd.scan  = 1'b1;
			ST_DRAIN:  cmd       = '0;
			ST_WRITE:  cmd.write = 1'b1;
			ST_FINISH: cmd.emit  = status.last_item;
			default:   cmd       = '0;
		endcase
	end

endmodule

>>> design/nrc_dp.sv
// ----------------------------------------------------------------------------
// nrc_dp
// Entry memory, area multiplier, chain compare/update and running best.
// ----------------------------------------------------------------------------
module nrc_dp import nrc_pkg::*; #(
	parameter int MAX_ITEMS = 128
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  cmd_t    cmd,
	output status_t status,
	output logic    done,
	output result_t result
);

	localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int AREA_W = 2 * SIDE_W + CNT_W;

	typedef struct packed {
		logic [SIDE_W-1:0] s;
		logic [SIDE_W-1:0] l;
		logic [CNT_W-1:0]  cnt;
		logic [AREA_W-1:0] area;
	} entry_t;

	entry_t mem [MAX_ITEMS];

	logic [SIDE_W-1:0] s_q, l_q;
	logic              last_q;
	logic [AREA_W-1:0] area_q, sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  n_q, rd_idx_q;
	logic              rd_vld_s1;
	entry_t            rd_data_s1;
	logic [CNT_W-1:0]  ov_cnt_q;
	logic [AREA_W-1:0] ov_area_q;
	logic              done_q;
	result_t           result_q;

	logic [2*SIDE_W-1:0] prod;
	logic                follow, take, ov_take;
	logic [CNT_W-1:0]    c2;
	logic [AREA_W-1:0]   a2;

	assign prod = s_q * l_q;

	// candidate: extend the chain ending at the entry just read
	always_comb begin
		if (cfg.grow_mode) begin
			follow = (s_q >= rd_data_s1.s) && (l_q >= rd_data_s1.l);
		end else begin
			follow = (s_q <= rd_data_s1.s) && (l_q <= rd_data_s1.l);
		end
		c2 = rd_data_s1.cnt + CNT_W'(1);
		a2 = rd_data_s1.area + area_q;
		if (c2 != cnt_q) begin
			take = c2 > cnt_q;
		end else begin
			take = cfg.prefer_max_area ? (a2 > sum_q) : (a2 < sum_q);
		end
		take = take && follow && rd_vld_s1;
		if (cnt_q != ov_cnt_q) begin
			ov_take = cnt_q > ov_cnt_q;
		end else begin
			ov_take = cfg.prefer_max_area ? (sum_q > ov_area_q) : (sum_q < ov_area_q);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q    <= (item.side_a < item.side_b) ? item.side_a : item.side_b;
			l_q    <= (item.side_a < item.side_b) ? item.side_b : item.side_a;
			last_q <= item.last_item;
		end
		if (cmd.mul) begin
			area_q <= AREA_W'(prod);
			sum_q  <= AREA_W'(prod);
			cnt_q  <= CNT_W'(1);
		end else if (take) begin
			sum_q <= a2;
			cnt_q <= c2;
		end
		if (cmd.emit) begin
			result_q.chain_length <= LEN_W'(ov_cnt_q);
			result_q.chain_area   <= SUM_W'(ov_area_q);
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[n_q[IDX_W-1:0]] <= '{s: s_q, l: l_q, cnt: cnt_q, area: sum_q};
		end
		rd_data_s1 <= mem[rd_idx_q[IDX_W-1:0]];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			ov_cnt_q  <= '0;
			ov_area_q <= '0;
			done_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			done_q    <= cmd.emit;
			if (cmd.mul) begin
				rd_idx_q <= '0;
			end else if (cmd.scan) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (cmd.write) begin
				n_q <= n_q + CNT_W'(1);
				if (ov_take) begin
					ov_cnt_q  <= cnt_q;
					ov_area_q <= sum_q;
				end
			end else if (cmd.emit) begin
				n_q       <= '0;
				ov_cnt_q  <= '0;
				ov_area_q <= '0;
			end
		end
	end

	assign status.full      = (n_q == CNT_W'(MAX_ITEMS));
	assign status.empty     = (n_q == '0);
	assign status.scan_last = (rd_idx_q == n_q - CNT_W'(1));
	assign status.last_item = last_q;

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> design/nested_rectangle_chain.sv
// ----------------------------------------------------------------------------
// nested_rectangle_chain
// Longest nested rectangle chain with min/max total area tie break.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item and raise start; the word is taken at a clock edge with
//   start high and busy low. Each rectangle is normalized (short side first)
//   and compared with every earlier stored rectangle of the current set.
//   Output: done pulses for one cycle with result (chain length, chain area);
//   only the word marked last_item gives a result, after which the set is
//   cleared. The receiver must take the word in that cycle; no stall exists.
//   Config: cfg_wr_en/cfg_addr/cfg_wdata write grow_mode (0) or
//   prefer_max_area (1), selected by cfg_addr; write only while busy is low.
// Steps, n = rectangles already stored in the set (n >= 1, store not full):
//   busy stays high through multiply, a scan of the n stored entries, drain,
//   store and finish, and no new word is taken until it falls; the single
//   read port of the entry memory scans one stored entry per cycle. A word
//   with no stored entries skips scan and drain; a word arriving with the
//   memory full goes from multiply straight to finish (it is dropped). done
//   is high in the first cycle with busy low after a last_item word.
// Reset: arst_n clears the sequencer, counters and both config registers;
//   the entry memory is not cleared, entries are read only after written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nested_rectangle_chain import nrc_pkg::*; #(
	parameter int MAX_ITEMS = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_GROW_MODE:       cfg_q.grow_mode       <= cfg_wdata[0];
				REG_PREFER_MAX_AREA: cfg_q.prefer_max_area <= cfg_wdata[0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	// sequencer
	nrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// storage, multiply, compare
	nrc_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.done   (done),
		.result (result)
	);

	// an accepted word always makes the block busy next cycle
	`NRC_ASSERT(a_start_busy, clk, arst_n, (start && !busy) |=> busy)
	// a result strobe lasts one cycle
	`NRC_ASSERT(a_done_pulse, clk, arst_n, done |=> !done)
	// the result comes out after the sequencer has returned to idle
	`NRC_ASSERT_NEVER(a_done_idle, clk, arst_n, done && busy)

endmodule

>>> dv/nested_rectangle_chain_tb.sv
// ----------------------------------------------------------------------------
// nested_rectangle_chain_tb
// Self-checking bench for the nested rectangle chain block. Rectangles go in
// over the start/busy port in sets. An in-bench dynamic program predicts the
// chain length and chain area of each set, and a monitor compares every done
// word against the oldest prediction. Directed sets cover extremes, both
// nesting directions, both tie breaks, register changes within a set and a
// set that overflows capacity. Random sets follow, with sender idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nested_rectangle_chain_tb import nrc_pkg::*;;

	localparam int MAX_ITEMS     = 128;
	localparam int AREA_W        = SUM_W + 1;
	// margin above the longest busy stretch, used for idle checks
	localparam int SETTLE_CYCLES = MAX_ITEMS + 8;
	localparam int RANDOM_WORDS  = 240;

	typedef enum int {
		SHAPE_CHAIN,
		SHAPE_SMALL,
		SHAPE_FULL,
		SHAPE_CORNER
	} shape_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	item_t                item = '0;
	logic                 done;
	result_t              result;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	nested_rectangle_chain #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Shadow copy of the block: registers, per-entry best chain, set totals
	// ------------------------------------------------------------------------
	logic              shadow_grow = 1'b0;
	logic              shadow_max_area = 1'b0;
	logic [SIDE_W-1:0] rect_short [MAX_ITEMS];
	logic [SIDE_W-1:0] rect_long [MAX_ITEMS];
	int unsigned       rect_len [MAX_ITEMS];
	logic [AREA_W-1:0] rect_area [MAX_ITEMS];
	int unsigned       rects_stored = 0;
	int unsigned       set_len = 0;
	logic [AREA_W-1:0] set_area = '0;

	// predicted chain results, oldest first
	result_t chain_results [$];

	int words_sent = 0;
	int words_dropped = 0;
	int sets_checked = 0;
	int reg_writes = 0;
	int mismatch_count = 0;
	bit no_idle = 1'b0;
	int trend_short = 0;
	int trend_long = 0;

	// chain (c1, a1) beats chain (c2, a2): longer wins, area breaks ties
	function automatic bit chain_beats(int unsigned c1, logic [AREA_W-1:0] a1,
			int unsigned c2, logic [AREA_W-1:0] a2);
		if (c1 != c2)
			return c1 > c2;
		return shadow_max_area ? (a1 > a2) : (a1 < a2);
	endfunction

	// Fold one accepted word into the shadow state; a last_item word closes
	// the set and queues its expected result.
	function automatic void track_rectangle(item_t w);
		logic [SIDE_W-1:0] s;
		logic [SIDE_W-1:0] l;
		logic [AREA_W-1:0] own_area;
		logic [AREA_W-1:0] sum;
		int unsigned       cnt;
		bit                fits;
		result_t           r;
		if (rects_stored < MAX_ITEMS) begin
			s = (w.side_a < w.side_b) ? w.side_a : w.side_b;
			l = (w.side_a < w.side_b) ? w.side_b : w.side_a;
			own_area = AREA_W'(s) * AREA_W'(l);
			cnt = 1;
			sum = own_area;
			for (int k = 0; k < rects_stored; k++) begin
				fits = shadow_grow ? (s >= rect_short[k] && l >= rect_long[k])
				                   : (s <= rect_short[k] && l <= rect_long[k]);
				if (fits && chain_beats(rect_len[k] + 1, rect_area[k] + own_area, cnt, sum)) begin
					cnt = rect_len[k] + 1;
					sum = rect_area[k] + own_area;
				end
			end
			rect_short[rects_stored] = s;
			rect_long[rects_stored] = l;
			rect_len[rects_stored] = cnt;
			rect_area[rects_stored] = sum;
			rects_stored++;
			if (chain_beats(cnt, sum, set_len, set_area)) begin
				set_len = cnt;
				set_area = sum;
			end
		end else begin
			words_dropped++;
		end
		if (w.last_item) begin
			r.chain_length = set_len[LEN_W-1:0];
			r.chain_area = set_area[SUM_W-1:0];
			chain_results.push_back(r);
			rects_stored = 0;
			set_len = 0;
			set_area = '0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic item_t rect(logic [SIDE_W-1:0] a, logic [SIDE_W-1:0] b, logic last);
		item_t w;
		w.side_a = a;
		w.side_b = b;
		w.last_item = last;
		return w;
	endfunction

	function automatic logic [SIDE_W-1:0] corner_side();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return 16'd1;
		2: return 16'h7FFF;
		3: return 16'h8000;
		4: return 16'hFFFE;
		default: return 16'hFFFF;
		endcase
	endfunction

	// Chain shapes walk a trend in the current nesting direction so that
	// long chains actually form; one word in five breaks away at random.
	function automatic item_t make_rect(shape_e shape, logic last);
		logic [SIDE_W-1:0] a;
		logic [SIDE_W-1:0] b;
		case (shape)
		SHAPE_CHAIN: begin
			if ($urandom_range(0, 4) == 0) begin
				a = 16'($urandom);
				b = 16'($urandom);
			end else begin
				if (shadow_grow) begin
					trend_short += $urandom_range(0, 300);
					trend_long += $urandom_range(0, 300);
					if (trend_short > 65535) trend_short = 65535;
					if (trend_long > 65535) trend_long = 65535;
				end else begin
					trend_short -= $urandom_range(0, 300);
					trend_long -= $urandom_range(0, 300);
					if (trend_short < 0) trend_short = 0;
					if (trend_long < 0) trend_long = 0;
				end
				a = 16'(trend_short);
				b = 16'(trend_long);
			end
		end
		SHAPE_SMALL: begin
			// tiny sides: lots of equal rectangles and area ties
			a = 16'($urandom_range(0, 15));
			b = 16'($urandom_range(0, 15));
		end
		SHAPE_FULL: begin
			a = 16'($urandom);
			b = 16'($urandom);
		end
		default: begin
			a = corner_side();
			b = corner_side();
		end
		endcase
		if ($urandom_range(0, 1))
			return rect(b, a, last);
		return rect(a, b, last);
	endfunction

	// Hold the word until the block takes it; unless the sender then idles, start
	// stays high on return so back-to-back words need no extra edge.
	task automatic send_word(input item_t w);
		item <= w;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		track_rectangle(w);
		words_sent++;
		if (!no_idle && $urandom_range(0, 99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Register writes only once every result is in and the block has had
	// time to finish any word that gives no result.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
		start <= 1'b0;
		while (chain_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_GROW_MODE)
			shadow_grow = val;
		else
			shadow_max_area = val;
		reg_writes++;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// one-rectangle sets at reset config: zero sides, full sides, mixed order
	task automatic test_single_rects();
		send_word(rect(16'h0000, 16'h0000, 1'b1));
		send_word(rect(16'hFFFF, 16'hFFFF, 1'b1));
		send_word(rect(16'hFFFF, 16'h0000, 1'b1));
		send_word(rect(16'hABCD, 16'h1234, 1'b1));
	endtask

	// Same set under all four register settings. Two longest chains with
	// different areas exist in each direction, so the tie break shows.
	task automatic test_tie_breaks();
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_GROW_MODE, m[1]);
			write_reg(REG_PREFER_MAX_AREA, m[0]);
			send_word(rect(16'd10, 16'd20, 1'b0));
			send_word(rect(16'd15, 16'd5, 1'b0));
			send_word(rect(16'd20, 16'd10, 1'b0));
			send_word(rect(16'd3, 16'd3, 1'b0));
			send_word(rect(16'd30, 16'd1, 1'b1));
		end
	endtask

	// registers flipped between words of one set; earlier entries stay
	task automatic test_config_within_set();
		send_word(rect(16'd5, 16'd5, 1'b0));
		send_word(rect(16'd9, 16'd3, 1'b0));
		write_reg(REG_GROW_MODE, 1'b0);
		send_word(rect(16'd4, 16'd2, 1'b0));
		write_reg(REG_PREFER_MAX_AREA, 1'b0);
		send_word(rect(16'd2, 16'd4, 1'b0));
		send_word(rect(16'd1, 16'd1, 1'b1));
	endtask

	// Fill the entry store with full-size squares (longest chain, largest
	// sum), then two more words: both dropped, the second still ends the set.
	task automatic test_full_capacity();
		write_reg(REG_GROW_MODE, 1'b0);
		write_reg(REG_PREFER_MAX_AREA, 1'b1);
		for (int k = 0; k < MAX_ITEMS; k++)
			send_word(rect(16'hFFFF, 16'hFFFF, 1'b0));
		send_word(rect(16'd1, 16'd2, 1'b0));
		send_word(rect(16'd7, 16'd9, 1'b1));
		// next set must start empty
		send_word(rect(16'd3, 16'd4, 1'b1));
	endtask

	task automatic test_random_sets();
		int     first_word;
		int     set_size;
		int     big_set;
		int     pick;
		shape_e shape;
		first_word = words_sent;
		big_set = $urandom_range(3, 12);
		for (int set_idx = 0; words_sent - first_word < RANDOM_WORDS; set_idx++) begin
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_GROW_MODE : REG_PREFER_MAX_AREA,
				          1'($urandom_range(0, 1)));
			if (set_idx == big_set)
				set_size = $urandom_range(MAX_ITEMS - 8, MAX_ITEMS + 6);
			else if ($urandom_range(0, 99) < 8)
				set_size = $urandom_range(11, 40);
			else
				set_size = $urandom_range(1, 10);
			pick = $urandom_range(0, 9);
			if (pick < 4)
				shape = SHAPE_CHAIN;
			else if (pick < 7)
				shape = SHAPE_SMALL;
			else if (pick < 9)
				shape = SHAPE_FULL;
			else
				shape = SHAPE_CORNER;
			if (shadow_grow) begin
				trend_short = $urandom_range(0, 200);
				trend_long = trend_short + $urandom_range(0, 200);
			end else begin
				trend_short = $urandom_range(60000, 65535);
				trend_long = $urandom_range(60000, 65535);
			end
			for (int k = 0; k < set_size; k++) begin
				// a long back-to-back stretch in the middle of the random part
				no_idle = (words_sent - first_word >= 60) && (words_sent - first_word < 180);
				if (k > 0 && $urandom_range(0, 99) == 0)
					write_reg($urandom_range(0, 1) ? REG_GROW_MODE : REG_PREFER_MAX_AREA,
					          1'($urandom_range(0, 1)));
				send_word(make_rect(shape, k == set_size - 1));
			end
		end
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Result monitor: done is a one-cycle strobe, no back-pressure
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (chain_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result: length %0d area %0d",
					         $realtime, result.chain_length, result.chain_area);
			end else begin
				want = chain_results.pop_front();
				sets_checked++;
				if (result.chain_length !== want.chain_length ||
						result.chain_area !== want.chain_area) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch: length exp %0d got %0d, area exp %0d got %0d",
						         $realtime, want.chain_length, result.chain_length,
						         want.chain_area, result.chain_area);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_rects();
		test_tie_breaks();
		test_config_within_set();
		test_full_capacity();
		test_random_sets();

		// drain: the last set's result comes after its final busy stretch
		start <= 1'b0;
		for (int n = 0; n < 20 * SETTLE_CYCLES && chain_results.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (chain_results.size() != 0) begin
			$display("%0d expected results never arrived", chain_results.size());
			mismatch_count += chain_results.size();
		end

		$display("Ran %0d words in %0d checked sets (%0d dropped at full capacity),",
		         words_sent, sets_checked, words_dropped);
		$display("%0d register writes; both nesting directions and both tie breaks; %0d mismatches.",
		         reg_writes, mismatch_count);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
